// ----- hw/rtl/sfc_pkg.sv -----
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and constants for the sphere frustum cull pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_ORIGIN = 3'd0;
  localparam logic [2:0] REG_TILT   = 3'd1;
  localparam logic [2:0] REG_FWD    = 3'd2;
  localparam logic [2:0] REG_RIGHT  = 3'd3;
  localparam logic [2:0] REG_UP     = 3'd4;
  localparam logic [2:0] REG_SLOPES = 3'd5;
  localparam logic [2:0] REG_LIMITS = 3'd6;

  // Radius growth: about 1.02 in Q.16 and 0.001 in Q.26
  localparam logic [36:0] RAD_GROW = 37'd66847;
  localparam logic [36:0] RAD_BIAS = 37'd67109;
  // Smallest depth used by the screen size test, about 0.1 in Q.26
  localparam logic signed [45:0] MIN_DEPTH = 46'sd6710886;

  typedef struct packed {
    logic signed [20:0] ox;
    logic signed [20:0] oy;
    logic signed [20:0] oz;
    logic signed [19:0] ys;
    logic signed [19:0] yz;
    logic signed [19:0] zs;
    logic signed [19:0] fx;
    logic signed [19:0] fy;
    logic signed [19:0] fz;
    logic signed [19:0] rx;
    logic signed [19:0] ry;
    logic signed [19:0] rz;
    logic signed [19:0] ux;
    logic signed [19:0] uy;
    logic signed [19:0] uz;
  } proj_cfg_t;

  typedef struct packed {
    logic [15:0] tanx;
    logic [15:0] tany;
    logic [15:0] sclx;
    logic [15:0] scly;
    logic [23:0] ppu;
    logic [15:0] minpix;
    logic [15:0] padpd;
  } test_cfg_t;

  // Camera space rock: grown radius, depth and side distances, all Q.26
  typedef struct packed {
    logic [36:0]        r;
    logic signed [45:0] z;
    logic [44:0]        ax;
    logic [44:0]        ay;
  } proj_res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sfc_cfg.sv -----
// ----------------------------------------------------------------------------
// sfc_cfg
// Configuration register file; unpacks fields for the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [63:0]       cfg_data,
  output sfc_pkg::proj_cfg_t     pcfg,
  output sfc_pkg::test_cfg_t     tcfg
);
  import sfc_pkg::*;

  logic [62:0] origin;
  logic [59:0] tilt;
  logic [59:0] fwd;
  logic [59:0] rgt;
  logic [59:0] up;
  logic [63:0] slopes;
  logic [55:0] limits;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin <= '0;
      tilt   <= '0;
      fwd    <= '0;
      rgt    <= '0;
      up     <= '0;
      slopes <= '0;
      limits <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN: origin <= cfg_data[62:0];
        REG_TILT:   tilt   <= cfg_data[59:0];
        REG_FWD:    fwd    <= cfg_data[59:0];
        REG_RIGHT:  rgt    <= cfg_data[59:0];
        REG_UP:     up     <= cfg_data[59:0];
        REG_SLOPES: slopes <= cfg_data;
        REG_LIMITS: limits <= cfg_data[55:0];
        default: ; // drop writes to unknown indexes
      endcase
    end
  end

  always_comb begin
    pcfg.ox = origin[20:0];
    pcfg.oy = origin[41:21];
    pcfg.oz = origin[62:42];
    pcfg.ys = tilt[19:0];
    pcfg.yz = tilt[39:20];
    pcfg.zs = tilt[59:40];
    pcfg.fx = fwd[19:0];
    pcfg.fy = fwd[39:20];
    pcfg.fz = fwd[59:40];
    pcfg.rx = rgt[19:0];
    pcfg.ry = rgt[39:20];
    pcfg.rz = rgt[59:40];
    pcfg.ux = up[19:0];
    pcfg.uy = up[39:20];
    pcfg.uz = up[59:40];
    tcfg.tanx   = slopes[15:0];
    tcfg.tany   = slopes[31:16];
    tcfg.sclx   = slopes[47:32];
    tcfg.scly   = slopes[63:48];
    tcfg.ppu    = limits[23:0];
    tcfg.minpix = limits[39:24];
    tcfg.padpd  = limits[55:40];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sfc_proj.sv -----
// ----------------------------------------------------------------------------
// sfc_proj
// Stages 1 to 4: grow radius, offset and tilt centre, project on camera axes.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_proj (
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire logic signed [20:0] rock_x,
  input  wire logic signed [20:0] rock_y,
  input  wire logic signed [20:0] rock_z,
  input  wire logic [19:0]        rock_radius,
  input  sfc_pkg::proj_cfg_t      pcfg,
  output sfc_pkg::proj_res_t      res
);
  import sfc_pkg::*;

  logic [36:0]        r1, r2, r3;
  logic signed [37:0] px1, px2;
  logic signed [40:0] pya1, pyb1, pza1;
  logic signed [42:0] py2;
  logic signed [41:0] pz2;
  logic signed [62:0] pfx, pfy, pfz, prx, pry, prz, pux, puy, puz;
  logic signed [62:0] df, dr, du, absr, absu;

  // Stage 1: radius, x offset, tilt products
  always_ff @(posedge clk) begin
    if (adv) begin
      r1   <= 37'(rock_radius) * RAD_GROW + RAD_BIAS;
      px1  <= {22'(pcfg.ox) + 22'(rock_x), 16'd0};
      pya1 <= 41'(rock_y) * 41'(pcfg.ys);
      pyb1 <= 41'(rock_z) * 41'(pcfg.yz);
      pza1 <= 41'(rock_z) * 41'(pcfg.zs);
    end
  end

  // Stage 2: finish tilted centre
  always_ff @(posedge clk) begin
    if (adv) begin
      r2  <= r1;
      px2 <= px1;
      py2 <= 43'($signed({pcfg.oy, 16'd0})) + 43'(pya1) - 43'(pyb1);
      pz2 <= 42'($signed({pcfg.oz, 16'd0})) + 42'(pza1);
    end
  end

  // Stage 3: nine axis products
  always_ff @(posedge clk) begin
    if (adv) begin
      r3  <= r2;
      pfx <= 63'(pcfg.fx) * 63'(px2);
      pfy <= 63'(pcfg.fy) * 63'(py2);
      pfz <= 63'(pcfg.fz) * 63'(pz2);
      prx <= 63'(pcfg.rx) * 63'(px2);
      pry <= 63'(pcfg.ry) * 63'(py2);
      prz <= 63'(pcfg.rz) * 63'(pz2);
      pux <= 63'(pcfg.ux) * 63'(px2);
      puy <= 63'(pcfg.uy) * 63'(py2);
      puz <= 63'(pcfg.uz) * 63'(pz2);
    end
  end

  // Stage 4: dot products, floor depth, magnitude of side distances
  always_comb begin
    df   = pfx + pfy + pfz;
    dr   = prx + pry + prz;
    du   = pux + puy + puz;
    absr = dr[62] ? -dr : dr;
    absu = du[62] ? -du : du;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res.r  <= r3;
      res.z  <= df[61:16];
      res.ax <= absr[60:16];
      res.ay <= absu[60:16];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sfc_test.sv -----
// ----------------------------------------------------------------------------
// sfc_test
// Stages 5 to 8: front, screen size and slope tests, combined into keep.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_test (
  input  wire logic          clk,
  input  wire logic          adv,
  input  sfc_pkg::proj_res_t pres,
  input  sfc_pkg::test_cfg_t tcfg,
  output logic               keep
);
  import sfc_pkg::*;

  logic [44:0] zc, zd;
  logic [47:0] fsum;
  logic        front5, front6, front7;
  logic        size6, size7;
  logic [36:0] r5;
  logic [60:0] rppu5, mz5, zpad5, ztx5, zty5, ztx6, zty6, ztx7, zty7;
  logic [44:0] ax5, ay5, ax6, ay6, ax7, ay7;
  logic [49:0] pad6;
  logic [65:0] pxs7, pys7;
  logic [66:0] bndx, bndy;

  always_comb begin
    zc   = pres.z[45] ? '0 : pres.z[44:0];
    zd   = (pres.z > MIN_DEPTH) ? pres.z[44:0] : MIN_DEPTH[44:0];
    fsum = 48'(pres.z) + 48'(pres.r);
  end

  // Stage 5: depth products
  always_ff @(posedge clk) begin
    if (adv) begin
      r5     <= pres.r;
      front5 <= ~fsum[47];
      rppu5  <= 61'(pres.r) * 61'(tcfg.ppu);
      mz5    <= 61'(tcfg.minpix) * 61'(zd);
      zpad5  <= 61'(zc) * 61'(tcfg.padpd);
      ztx5   <= 61'(zc) * 61'(tcfg.tanx);
      zty5   <= 61'(zc) * 61'(tcfg.tany);
      ax5    <= pres.ax;
      ay5    <= pres.ay;
    end
  end

  // Stage 6: size compare, padded radius
  always_ff @(posedge clk) begin
    if (adv) begin
      front6 <= front5;
      size6  <= 61'(rppu5[60:4]) >= mz5;
      pad6   <= 50'(r5) + 50'(zpad5[60:12]);
      ztx6   <= ztx5;
      zty6   <= zty5;
      ax6    <= ax5;
      ay6    <= ay5;
    end
  end

  // Stage 7: pad scaled per side
  always_ff @(posedge clk) begin
    if (adv) begin
      front7 <= front6;
      size7  <= size6;
      pxs7   <= 66'(pad6) * 66'(tcfg.sclx);
      pys7   <= 66'(pad6) * 66'(tcfg.scly);
      ztx7   <= ztx6;
      zty7   <= zty6;
      ax7    <= ax6;
      ay7    <= ay6;
    end
  end

  // Stage 8: slope bounds, held exact so no saturation is needed
  always_comb begin
    bndx = 67'(ztx7) + 67'(pxs7);
    bndy = 67'(zty7) + 67'(pys7);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      keep <= front7 & size7 & (67'({ax7, 12'd0}) <= bndx) & (67'({ay7, 12'd0}) <= bndy);
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sphere_frustum_cull_top.sv -----
// ----------------------------------------------------------------------------
// sphere_frustum_cull_top
// Per-rock frustum visibility test, one rock per cycle while no held result stalls it.
// ----------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  in       | in_valid / in_stall   | rock_id, rock_x/y/z, rock_radius, is_last
//  out      | out_valid / out_stall | kept_id, keep, pass_end
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  Eight register stages; a rock's result is offered from the eighth stage, and
//  one rock is taken every cycle while no held result stalls the pipeline.
//  The eight stages advance together; a held result at the output freezes them.
//  Synchronous reset clears the configuration registers and the stage valids.
//  Configuration writes are always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_frustum_cull_top #(
  parameter int ROCK_ID_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [ROCK_ID_BITS-1:0] rock_id,
  input  wire logic signed [20:0]      rock_x,
  input  wire logic signed [20:0]      rock_y,
  input  wire logic signed [20:0]      rock_z,
  input  wire logic [19:0]             rock_radius,
  input  wire logic                    is_last,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic [ROCK_ID_BITS-1:0]      kept_id,
  output logic                         keep,
  output logic                         pass_end,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [2:0]              cfg_index,
  input  wire logic [63:0]             cfg_data
);
  import sfc_pkg::*;

  localparam int NSTAGE = 8;

  proj_cfg_t pcfg;
  test_cfg_t tcfg;
  proj_res_t pres;

  logic                    adv;
  logic                    vld    [NSTAGE];
  logic [ROCK_ID_BITS-1:0] idp    [NSTAGE];
  logic                    lastp  [NSTAGE];

  assign adv       = ~(vld[NSTAGE-1] & out_stall);
  assign in_stall  = ~adv;
  assign cfg_ready = 1'b1;

  sfc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pcfg      (pcfg),
    .tcfg      (tcfg)
  );

  sfc_proj u_proj (
    .clk         (clk),
    .adv         (adv),
    .rock_x      (rock_x),
    .rock_y      (rock_y),
    .rock_z      (rock_z),
    .rock_radius (rock_radius),
    .pcfg        (pcfg),
    .res         (pres)
  );

  sfc_test u_test (
    .clk  (clk),
    .adv  (adv),
    .pres (pres),
    .tcfg (tcfg),
    .keep (keep)
  );

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NSTAGE; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (adv) begin
      vld[0] <= in_valid;
      for (int i = 1; i < NSTAGE; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      idp[0]   <= rock_id;
      lastp[0] <= is_last;
      for (int i = 1; i < NSTAGE; i++) begin
        idp[i]   <= idp[i-1];
        lastp[i] <= lastp[i-1];
      end
    end
  end

  assign out_valid = vld[NSTAGE-1];
  assign kept_id   = idp[NSTAGE-1];
  assign pass_end  = lastp[NSTAGE-1];

`ifndef SYNTHESIS
  // A held result keeps its keep flag from the test stages
  a_keep_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(keep)))
    else $error("keep changed while result held");

  // Nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    $fell(rst) |-> !out_valid)
    else $error("result valid after reset");

  // The input side only stalls behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (vld[NSTAGE-1] && out_stall))
    else $error("input stalled without a held result");
`endif

endmodule

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams rocks through the frustum cull block under random valid gaps and
// output stalls, across several camera setups, and checks every result
// against a fixed-point visibility predictor kept in the bench, or a typed value.
// ----------------------------------------------------------------------------
module tb_top;
  import sfc_pkg::*;

  localparam int LATENCY = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [15:0] rock_id = '0;
  logic signed [20:0] rock_x = '0, rock_y = '0, rock_z = '0;
  logic [19:0] rock_radius = '0;
  logic is_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] kept_id;
  logic keep, pass_end;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  sphere_frustum_cull_top #(.ROCK_ID_BITS(16)) dut (.*);

  typedef struct packed {
    logic [15:0] id;
    logic        keep;
    logic        last;
  } verdict_t;

  logic [63:0] cam_regs [7];
  verdict_t    verdict_q[$];
  int          fail_cnt = 0;
  int          rock_cnt = 0;
  int          verdict_cnt = 0;
  int          kept_cnt = 0;
  int          stall_hold = 0;
  bit          stall_on = 1'b1;

  function automatic logic signed [63:0] sfld(logic [63:0] v, int lo, int w);
    logic [63:0] m;
    m = (64'd1 << w) - 1;
    return $signed(((v >> lo) & m) ^ (64'd1 << (w - 1))) - $signed(64'd1 << (w - 1));
  endfunction

  function automatic logic [63:0] ufld(logic [63:0] v, int lo, int w);
    return (v >> lo) & ((64'd1 << w) - 1);
  endfunction

  function automatic logic signed [63:0] project(logic [63:0] ax, logic signed [63:0] px,
                                                 logic signed [63:0] py,
                                                 logic signed [63:0] pz);
    return sfld(ax, 0, 20) * px + sfld(ax, 20, 20) * py + sfld(ax, 40, 20) * pz;
  endfunction

  function automatic bit side_fits(logic [63:0] side, logic [63:0] zc, logic [63:0] tanq,
                                   logic [63:0] pad, logic [63:0] scl);
    logic [127:0] bound;
    bound = zc * tanq + {64'd0, pad} * scl;
    return {64'd0, side << 12} <= bound;
  endfunction

  function automatic bit rock_visible(logic signed [20:0] x, logic signed [20:0] y,
                                      logic signed [20:0] z, logic [19:0] rad);
    logic signed [63:0] r, px, py, pz, dz, dr, du, depth;
    logic [63:0] ax, ay, zc, zd, ppu, minpix, padpd, pad, sl;
    bit front, big, horiz, vert;
    r  = $signed({44'd0, rad}) * 66847 + 67109;
    px = (sfld(cam_regs[REG_ORIGIN], 0, 21) + x) * 65536;
    py = sfld(cam_regs[REG_ORIGIN], 21, 21) * 65536 + y * sfld(cam_regs[REG_TILT], 0, 20)
         - z * sfld(cam_regs[REG_TILT], 20, 20);
    pz = sfld(cam_regs[REG_ORIGIN], 42, 21) * 65536 + z * sfld(cam_regs[REG_TILT], 40, 20);
    dz = project(cam_regs[REG_FWD], px, py, pz);
    dr = project(cam_regs[REG_RIGHT], px, py, pz);
    du = project(cam_regs[REG_UP], px, py, pz);
    depth = dz >>> 16;
    ax = (dr < 0 ? -dr : dr) >> 16;
    ay = (du < 0 ? -du : du) >> 16;
    zc = depth > 0 ? depth : 0;
    zd = depth > 6710886 ? depth : 6710886;
    sl = cam_regs[REG_SLOPES];
    ppu = ufld(cam_regs[REG_LIMITS], 0, 24);
    minpix = ufld(cam_regs[REG_LIMITS], 24, 16);
    padpd = ufld(cam_regs[REG_LIMITS], 40, 16);
    pad = r + ((zc * padpd) >> 12);
    front = depth >= -r;
    big = ((r * ppu) >> 4) >= minpix * zd;
    horiz = side_fits(ax, zc, ufld(sl, 0, 16), pad, ufld(sl, 32, 16));
    vert = side_fits(ay, zc, ufld(sl, 16, 16), pad, ufld(sl, 48, 16));
    return front && big && horiz && vert;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < 7) begin
      case (idx)
        REG_ORIGIN: cam_regs[idx] = val & 64'h7FFF_FFFF_FFFF_FFFF;
        REG_SLOPES: cam_regs[idx] = val;
        REG_LIMITS: cam_regs[idx] = val & 64'h00FF_FFFF_FFFF_FFFF;
        default:    cam_regs[idx] = val & 64'h0FFF_FFFF_FFFF_FFFF;
      endcase
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // expected keep is taken from the predictor unless a typed value is given
  task automatic send_rock(logic [15:0] id, logic signed [20:0] x, logic signed [20:0] y,
                           logic signed [20:0] z, logic [19:0] rad, logic last,
                           int typed_keep = -1);
    verdict_t v;
    v.id = id;
    v.keep = typed_keep < 0 ? rock_visible(x, y, z, rad) : typed_keep[0];
    v.last = last;
    rock_id <= id; rock_x <= x; rock_y <= y; rock_z <= z;
    rock_radius <= rad; is_last <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    verdict_q.insert(verdict_q.size(), v);
    rock_cnt++;
    @(negedge clk);
    if (($urandom_range(0, 3) == 0)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(5, 30) : $urandom_range(1, 2))
        @(negedge clk);
    end
  endtask

  // called at a falling edge, straight after the last request
  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(negedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    verdict_t e;
    if (!rst && out_valid && !out_stall) begin
      verdict_cnt++;
      if (verdict_q.size() == 0) begin
        $error("result with no rock outstanding: id %0d", kept_id);
        fail_cnt++;
      end else begin
        e = verdict_q.pop_front();
        kept_cnt += keep;
        if (kept_id !== e.id) begin
          $error("kept_id expected %0d got %0d", e.id, kept_id); fail_cnt++;
        end
        if (keep !== e.keep) begin
          $error("keep expected %0d got %0d (id %0d)", e.keep, keep, e.id); fail_cnt++;
        end
        if (pass_end !== e.last) begin
          $error("pass_end expected %0d got %0d", e.last, pass_end); fail_cnt++;
        end
      end
    end
  end

  // Output stall: runs of short stalls, occasional long hold, quiet stretches
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold--;
    end else if (!stall_on || $urandom_range(0, 99) < 30) out_stall <= 1'b0;
    else if ($urandom_range(0, 49) == 0) begin
      out_stall <= 1'b1;
      stall_hold = $urandom_range(5, 30);
    end else out_stall <= $urandom_range(0, 3) == 0;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  typedef struct {
    logic [15:0] id;
    logic signed [20:0] x, y, z;
    logic [19:0] rad;
    logic last;
    int typed;
  } rock_row_t;

  localparam logic [63:0] UNIT = 64'd65536;

  initial begin
    rock_row_t rows[$];
    logic [63:0] fwd, rgt, upv;
    int phase;
    for (int i = 0; i < 7; i++) cam_regs[i] = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // After reset all factors are zero: depth 0, no size or slope limit -> keep all
    rows = '{
      '{16'h0000, 21'sd0, 21'sd0, 21'sd0, 20'd0, 1'b0, 1},
      '{16'hFFFF, 21'sh0FFFFF, 21'sh0FFFFF, 21'sh0FFFFF, 20'hFFFFF, 1'b1, 1},
      '{16'hA5A5, -21'sd1048576, -21'sd1048576, -21'sd1048576, 20'h55555, 1'b0, 1}
    };
    foreach (rows[i])
      send_rock(rows[i].id, rows[i].x, rows[i].y, rows[i].z, rows[i].rad, rows[i].last,
                rows[i].typed);
    drain();

    // Identity camera, looking down z
    write_reg(REG_ORIGIN, 64'd0);
    write_reg(REG_TILT, (UNIT << 40) | UNIT);
    write_reg(REG_FWD, UNIT << 40);
    write_reg(REG_RIGHT, UNIT);
    write_reg(REG_UP, UNIT << 20);
    write_reg(REG_SLOPES, {16'd4096, 16'd4096, 16'd4096, 16'd4096});
    write_reg(REG_LIMITS, {16'd0, 16'd16, 24'd25600});
    write_reg(3'd7, 64'hFFFF_FFFF_FFFF_FFFF);  // unknown index: ignore
    rows = '{
      '{16'd1, 21'sd0, 21'sd0, 21'sd10240, 20'd1024, 1'b0, 1},
      '{16'd2, 21'sd0, 21'sd0, -21'sd10240, 20'd1024, 1'b0, 0},
      '{16'd3, 21'sd0, 21'sd0, 21'sd50, 20'd0, 1'b0, -1},
      '{16'd4, 21'sd0, 21'sd0, -21'sd50, 20'd100, 1'b0, -1},
      '{16'd5, 21'sd20480, 21'sd0, 21'sd10240, 20'd1024, 1'b0, -1},
      '{16'd6, 21'sd0, -21'sd20480, 21'sd10240, 20'd1024, 1'b0, -1},
      '{16'd7, 21'sh0FFFFF, 21'sh0FFFFF, 21'sh0FFFFF, 20'hFFFFF, 1'b0, -1},
      '{16'd8, -21'sd1048576, -21'sd1048576, 21'sh0FFFFF, 20'hFFFFF, 1'b0, -1},
      '{16'd9, 21'sd0, 21'sd0, 21'sh0FFFFF, 20'd1, 1'b1, -1}
    };
    foreach (rows[i])
      send_rock(rows[i].id, rows[i].x, rows[i].y, rows[i].z, rows[i].rad, rows[i].last,
                rows[i].typed);
    // Extreme settings: large slopes give the widest side bounds
    drain();
    write_reg(REG_SLOPES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_LIMITS, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_ORIGIN, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_TILT, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int i = 0; i < 8; i++)
      send_rock($urandom, $urandom, $urandom, $urandom, $urandom, i == 7);
    drain();

    for (phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        fwd = UNIT << 40; rgt = UNIT; upv = UNIT << 20;
        write_reg(REG_TILT, (UNIT << 40) | UNIT);
        write_reg(REG_ORIGIN, 64'd0);
      end else begin
        fwd = {$urandom, $urandom}; rgt = {$urandom, $urandom}; upv = {$urandom, $urandom};
        write_reg(REG_TILT, {$urandom, $urandom});
        write_reg(REG_ORIGIN, phase == 5 ? 64'hFFFF_FFFF_FFFF_FFFF : {$urandom, $urandom});
      end
      write_reg(REG_FWD, fwd);
      write_reg(REG_RIGHT, rgt);
      write_reg(REG_UP, upv);
      write_reg(REG_SLOPES, phase == 1 ? 64'd0 : {$urandom, $urandom});
      write_reg(REG_LIMITS, phase == 2 ? 64'd0 : {$urandom, $urandom} & 64'h00FF_0FFF_00FF_FFFF);
      stall_on = (phase != 3);
      for (int i = 0; i < 180; i++) begin
        // Near rocks of modest size in most items, full range now and then
        if ($urandom_range(0, 3) == 0)
          send_rock($urandom, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
        else
          send_rock($urandom, $signed(21'($urandom_range(0, 40000))) - 20000,
                    $signed(21'($urandom_range(0, 40000))) - 20000,
                    $urandom_range(0, 60000), $urandom_range(0, 8000),
                    $urandom_range(0, 15) == 0);
        if (i == 90) begin
          in_valid <= 1'b0;
          while (verdict_q.size() != 0) @(negedge clk);
        end
      end
      drain();
    end

    $display("Covered %0d rocks over reset, identity, extreme and random cameras; %0d kept.",
             rock_cnt, kept_cnt);
    if (fail_cnt == 0 && verdict_q.size() == 0 && verdict_cnt == rock_cnt)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// ----- sim.f -----
hw/rtl/sfc_pkg.sv
hw/rtl/sfc_cfg.sv
hw/rtl/sfc_proj.sv
hw/rtl/sfc_test.sv
hw/rtl/sphere_frustum_cull_top.sv
bench/tb_top.sv
